// ----- rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue: request codes,
// result status codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int COST_BITS_DEF  = 20;
  localparam int COORD_BITS_DEF = 5;
  localparam int HEADING_BITS   = 2;
  localparam int STATUS_BITS    = 2;

  // request codes on in_cmd
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_POP_MOVED,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } fsm_state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_ROOT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ENTRY,
    WR_PARENT,
    WR_CHILD
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    fill_inc;
    logic    fill_dec;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    up_step;
    logic    dn_step;
    logic    cap_top;
    logic    cap_moved;
    logic    cap_left;
    logic    cmp_right;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_push;
    logic in_err;
    logic at_root;
    logic parent_le;
    logic kid_ok;
    logic right_ok;
    logic moved_le;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/bmhq_dp.sv -----
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory with registered read, moving entry, chosen
// child, hole position, fill count and the output register.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
  parameter int COST_BITS  = bmhq_pkg::COST_BITS_DEF,
  parameter int COORD_BITS = bmhq_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_cmd,
  input  logic [COST_BITS-1:0]                  in_entry_cost,
  input  logic [COORD_BITS-1:0]                 in_entry_row,
  input  logic [COORD_BITS-1:0]                 in_entry_col,
  input  logic [bmhq_pkg::HEADING_BITS-1:0]     in_entry_heading,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bmhq_pkg::STATUS_BITS-1:0]      out_status,
  output logic [COST_BITS-1:0]                  out_cost,
  output logic [COORD_BITS-1:0]                 out_row,
  output logic [COORD_BITS-1:0]                 out_col,
  output logic [bmhq_pkg::HEADING_BITS-1:0]     out_heading,
  output logic [$clog2(DEPTH+1)-1:0]            out_occupancy,
  input  bmhq_pkg::dp_cmd_t                     cmd,
  output bmhq_pkg::dp_stat_t                    stat
);
  import bmhq_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int KW      = AW + 2;
  localparam int EW      = COST_BITS + 2 * COORD_BITS + HEADING_BITS;
  localparam int COL_LO  = HEADING_BITS;
  localparam int ROW_LO  = COL_LO + COORD_BITS;

  logic [EW-1:0]  mem [DEPTH];
  logic [EW-1:0]  rd_data_r;
  logic [EW-1:0]  e_r;
  logic [EW-1:0]  child_r;
  logic [EW-1:0]  top_r;
  stat_code_t     status_r;
  logic [AW-1:0]  pos_r;
  logic [AW-1:0]  pos_nxt;
  logic [CW-1:0]  fill_r;
  logic [CW-1:0]  fill_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic [STATUS_BITS-1:0]  out_status_r;
  logic [COST_BITS-1:0]    out_cost_r;
  logic [COORD_BITS-1:0]   out_row_r;
  logic [COORD_BITS-1:0]   out_col_r;
  logic [HEADING_BITS-1:0] out_heading_r;
  logic [CW-1:0]           out_occ_r;

  logic [AW-1:0]  pos_m1;
  logic [AW-1:0]  parent_addr;
  logic [KW-1:0]  left_w;
  logic [KW-1:0]  right_w;
  logic [KW-1:0]  fill_w;
  logic           use_right;
  logic [EW-1:0]  chosen;
  logic           full;
  logic           empty;
  logic [AW-1:0]  rd_addr;
  logic           rd_en;
  logic [EW-1:0]  wr_data;
  logic           wr_en;
  logic [COST_BITS-1:0] e_cost;
  logic [COST_BITS-1:0] rd_cost;
  logic [COST_BITS-1:0] child_cost;
  logic [COST_BITS-1:0] chosen_cost;

  assign e_cost      = e_r[EW-1 -: COST_BITS];
  assign rd_cost     = rd_data_r[EW-1 -: COST_BITS];
  assign child_cost  = child_r[EW-1 -: COST_BITS];

  assign pos_m1      = pos_r - AW'(1);
  assign parent_addr = pos_m1 >> 1;
  assign left_w      = {1'b0, pos_r, 1'b1};
  assign right_w     = left_w + KW'(1);
  assign fill_w      = KW'(fill_r);

  // right child wins only when strictly cheaper
  assign use_right   = cmd.cmp_right && (rd_cost < child_cost);
  assign chosen      = use_right ? rd_data_r : child_r;
  assign chosen_cost = chosen[EW-1 -: COST_BITS];

  assign full  = (fill_r == CW'(DEPTH));
  assign empty = (fill_r == '0);

  always_comb begin
    stat.in_push   = (in_cmd == CMD_PUSH);
    stat.in_err    = (in_cmd == CMD_PUSH) ? full : empty;
    stat.at_root   = (pos_r == '0);
    stat.parent_le = (rd_cost <= e_cost);
    stat.kid_ok    = (left_w < fill_w);
    stat.right_ok  = (right_w < fill_w);
    stat.moved_le  = (e_cost <= chosen_cost);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PARENT: rd_addr = parent_addr;
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = fill_r[AW-1:0];
      RD_LEFT:   rd_addr = left_w[AW-1:0];
      RD_RIGHT:  rd_addr = right_w[AW-1:0];
      default:   rd_addr = '0;
    endcase
    rd_en = (cmd.rd_sel != RD_NONE);
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_ENTRY:  wr_data = e_r;
      WR_PARENT: wr_data = rd_data_r;
      WR_CHILD:  wr_data = chosen;
      default:   wr_data = e_r;
    endcase
    wr_en = (cmd.wr_sel != WR_NONE);
  end

  // entry memory: every write lands on the current hole
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      e_r      <= {in_entry_cost, in_entry_row, in_entry_col, in_entry_heading};
      top_r    <= '0;
      status_r <= stat.in_err ? ((in_cmd == CMD_PUSH) ? STAT_FULL : STAT_EMPTY) : STAT_OK;
    end
    if (cmd.cap_top) begin
      top_r <= rd_data_r;
    end
    if (cmd.cap_moved) begin
      e_r <= rd_data_r;
    end
    if (cmd.cap_left) begin
      child_r <= rd_data_r;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load_in) begin
      pos_nxt = (in_cmd == CMD_PUSH) ? fill_r[AW-1:0] : '0;
    end else if (cmd.up_step) begin
      pos_nxt = parent_addr;
    end else if (cmd.dn_step) begin
      pos_nxt = use_right ? right_w[AW-1:0] : left_w[AW-1:0];
    end

    fill_nxt = fill_r;
    if (cmd.fill_inc) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CW'(1);
    end

    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= status_r;
      out_cost_r    <= top_r[EW-1 -: COST_BITS];
      out_row_r     <= top_r[ROW_LO +: COORD_BITS];
      out_col_r     <= top_r[COL_LO +: COORD_BITS];
      out_heading_r <= top_r[HEADING_BITS-1:0];
      out_occ_r     <= fill_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_cost      = out_cost_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_heading   = out_heading_r;
  assign out_occupancy = out_occ_r;

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer of the heap: accepts one request, walks the sift-up or
// sift-down loop one level at a time and hands the result to the output.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmhq_pkg::dp_stat_t stat,
  output bmhq_pkg::dp_cmd_t  cmd
);
  import bmhq_pkg::*;

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_err) begin
            state_nxt = S_DONE;
          end else if (stat.in_push) begin
            state_nxt = S_UP;
          end else begin
            state_nxt = S_POP_ROOT;
          end
        end
      end
      S_UP:        state_nxt = stat.at_root ? S_DONE : S_UP_CMP;
      S_UP_CMP:    state_nxt = stat.parent_le ? S_DONE : S_UP;
      S_POP_ROOT:  state_nxt = S_POP_LAST;
      S_POP_LAST:  state_nxt = S_POP_MOVED;
      S_POP_MOVED: state_nxt = S_DN;
      S_DN:        state_nxt = stat.kid_ok ? S_DN_L : S_DONE;
      S_DN_L:      state_nxt = stat.right_ok ? S_DN_R : S_DN_CMP;
      S_DN_R:      state_nxt = stat.moved_le ? S_DONE : S_DN;
      S_DN_CMP:    state_nxt = stat.moved_le ? S_DONE : S_DN;
      S_DONE:      state_nxt = stat.out_free ? S_IDLE : S_DONE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NONE;
    cmd.wr_sel = WR_NONE;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_in  = in_valid;
        cmd.fill_inc = in_valid && stat.in_push && !stat.in_err;
      end
      S_UP: begin
        if (stat.at_root) begin
          cmd.wr_sel = WR_ENTRY;
        end else begin
          cmd.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        if (stat.parent_le) begin
          cmd.wr_sel = WR_ENTRY;
        end else begin
          cmd.wr_sel  = WR_PARENT;
          cmd.up_step = 1'b1;
        end
      end
      S_POP_ROOT: begin
        cmd.rd_sel   = RD_ROOT;
        cmd.fill_dec = 1'b1;
      end
      S_POP_LAST: begin
        cmd.cap_top = 1'b1;
        cmd.rd_sel  = RD_LAST;
      end
      S_POP_MOVED: begin
        cmd.cap_moved = 1'b1;
      end
      S_DN: begin
        if (stat.kid_ok) begin
          cmd.rd_sel = RD_LEFT;
        end else begin
          cmd.wr_sel = WR_ENTRY;
        end
      end
      S_DN_L: begin
        cmd.cap_left = 1'b1;
        if (stat.right_ok) begin
          cmd.rd_sel = RD_RIGHT;
        end
      end
      S_DN_R, S_DN_CMP: begin
        cmd.cmp_right = (state_r == S_DN_R);
        if (stat.moved_le) begin
          cmd.wr_sel = WR_ENTRY;
        end else begin
          cmd.wr_sel  = WR_CHILD;
          cmd.dn_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd.load_out = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/binary_min_heap_queue_unit.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Array-based binary min-heap priority queue keyed on cost, with row,
// column and heading carried as payload.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while the sequencer is idle,
// and every request returns exactly one result. A push reads the parent of
// the hole, compares, and moves the parent down while the new entry climbs;
// a pop reads the root, then the last entry, which descends: the left child
// and, if present, the right child are read and the cheaper is compared.
// Each level needs one read of the entry memory, with its registered read,
// and one compare before the hole can move. Pop on an empty heap and push
// on a full heap leave the heap untouched and report a status code with
// zero payload. Results wait in an output register, so the next request is
// accepted while an earlier result is still waiting to be taken.
// Equal costs resolve as the classic array algorithm does: sift-up stops on
// a parent of equal cost, sift-down takes the right child only when strictly
// cheaper and stops on a child of equal cost. No clearing pass is needed
// after reset; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit #(
  parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
  parameter int COST_BITS  = bmhq_pkg::COST_BITS_DEF,
  parameter int COORD_BITS = bmhq_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [COST_BITS-1:0]              in_entry_cost,
  input  logic [COORD_BITS-1:0]             in_entry_row,
  input  logic [COORD_BITS-1:0]             in_entry_col,
  input  logic [bmhq_pkg::HEADING_BITS-1:0] in_entry_heading,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bmhq_pkg::STATUS_BITS-1:0]  out_status,
  output logic [COST_BITS-1:0]              out_cost,
  output logic [COORD_BITS-1:0]             out_row,
  output logic [COORD_BITS-1:0]             out_col,
  output logic [bmhq_pkg::HEADING_BITS-1:0] out_heading,
  output logic [$clog2(DEPTH+1)-1:0]        out_occupancy
);
  import bmhq_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memory, hole pointer, fill count and output register
  bmhq_dp #(
    .DEPTH      (DEPTH),
    .COST_BITS  (COST_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_entry_cost    (in_entry_cost),
    .in_entry_row     (in_entry_row),
    .in_entry_col     (in_entry_col),
    .in_entry_heading (in_entry_heading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_cost         (out_cost),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_heading      (out_heading),
    .out_occupancy    (out_occupancy),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// ----- rtl/bmhq_checker.sv -----
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker #(
  parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
  parameter int COST_BITS  = bmhq_pkg::COST_BITS_DEF,
  parameter int COORD_BITS = bmhq_pkg::COORD_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [bmhq_pkg::STATUS_BITS-1:0]  out_status,
  input logic [COST_BITS-1:0]              out_cost,
  input logic [COORD_BITS-1:0]             out_row,
  input logic [COORD_BITS-1:0]             out_col,
  input logic [bmhq_pkg::HEADING_BITS-1:0] out_heading,
  input logic [$clog2(DEPTH+1)-1:0]        out_occupancy
);
  import bmhq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_cost)
      && $stable(out_row) && $stable(out_col) && $stable(out_heading)
      && $stable(out_occupancy))
    else $error("stalled result changed");

  // one request in flight: the sequencer leaves idle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // drop payload on a rejected request
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY || out_status == STAT_FULL)
      |-> out_cost == '0 && out_row == '0 && out_col == '0 && out_heading == '0)
    else $error("rejected request carries payload");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_occupancy == CW'(DEPTH))
    else $error("full status with heap not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_occupancy == '0)
    else $error("empty status with heap not empty");

endmodule

bind binary_min_heap_queue_unit bmhq_checker #(
  .DEPTH      (DEPTH),
  .COST_BITS  (COST_BITS),
  .COORD_BITS (COORD_BITS)
) u_bmhq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_cost         (out_cost),
  .out_row          (out_row),
  .out_col          (out_col),
  .out_heading      (out_heading),
  .out_occupancy    (out_occupancy)
);

// ----- tb/binary_min_heap_queue_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit_tb
// Self-checking bench for the min-heap queue. A shadow heap built on the same
// array algorithm predicts every result. Named tests cover pops on an empty
// heap, extreme fields and equal costs, output back-pressure, and a long
// stretch of random push/pop traffic. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit_tb;
  import bmhq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int COST_W       = COST_BITS_DEF;
  localparam int COORD_W      = COORD_BITS_DEF;
  localparam int OCC_W        = $clog2(DEPTH + 1);
  localparam int IDLE_PCT     = 22;
  localparam int LIMIT_CYCLES = 1_000_000;
  // settle past the longest request at the end
  localparam int DRAIN_CYCLES = 48;

  // heading codes of the entry payload
  localparam logic [HEADING_BITS-1:0] HEAD_NORTH = 2'd0;
  localparam logic [HEADING_BITS-1:0] HEAD_EAST  = 2'd1;
  localparam logic [HEADING_BITS-1:0] HEAD_SOUTH = 2'd2;
  localparam logic [HEADING_BITS-1:0] HEAD_WEST  = 2'd3;

  localparam logic [COST_W-1:0]  COST_MAX  = '1;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  typedef struct packed {
    logic [COST_W-1:0]       cost;
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic [HEADING_BITS-1:0] heading;
  } heap_entry_t;

  typedef struct packed {
    stat_code_t              status;
    logic [COST_W-1:0]       cost;
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic [HEADING_BITS-1:0] heading;
    logic [OCC_W-1:0]        occupancy;
  } heap_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_cmd;
  logic [COST_W-1:0]       in_entry_cost;
  logic [COORD_W-1:0]      in_entry_row;
  logic [COORD_W-1:0]      in_entry_col;
  logic [HEADING_BITS-1:0] in_entry_heading;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_BITS-1:0]  out_status;
  logic [COST_W-1:0]       out_cost;
  logic [COORD_W-1:0]      out_row;
  logic [COORD_W-1:0]      out_col;
  logic [HEADING_BITS-1:0] out_heading;
  logic [OCC_W-1:0]        out_occupancy;

  // shadow copy of the heap array and its fill count
  heap_entry_t  shadow_heap [DEPTH];
  int           shadow_fill;
  // results predicted at request acceptance, oldest first
  heap_result_t awaited_results [$];

  int mismatch_count;
  int cycle_count;
  // when set, neither side idles
  bit steady_traffic;
  // cycles the receiver still has to hold off; set by a test, counted down below
  int rx_hold_cycles;

  binary_min_heap_queue_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_entry_cost    (in_entry_cost),
    .in_entry_row     (in_entry_row),
    .in_entry_col     (in_entry_col),
    .in_entry_heading (in_entry_heading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_cost         (out_cost),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_heading      (out_heading),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow heap and return the result it causes.
  // Sift-up stops on a parent of equal cost; sift-down takes the right child
  // only when strictly cheaper and stops on a child of equal cost.
  function automatic heap_result_t predict_request(input logic cmd, input heap_entry_t item);
    heap_result_t r;
    heap_entry_t  moved;
    int           pos;
    int           up;
    int           kid;
    bit           settled;
    r        = '0;
    r.status = STAT_OK;
    settled  = 1'b0;
    if (cmd == CMD_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = shadow_fill;
        shadow_fill++;
        while (pos > 0 && !settled) begin
          up = (pos - 1) / 2;
          if (shadow_heap[up].cost <= item.cost) begin
            settled = 1'b1;
          end else begin
            shadow_heap[pos] = shadow_heap[up];
            pos = up;
          end
        end
        shadow_heap[pos] = item;
      end
    end else if (shadow_fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.cost    = shadow_heap[0].cost;
      r.row     = shadow_heap[0].row;
      r.col     = shadow_heap[0].col;
      r.heading = shadow_heap[0].heading;
      shadow_fill--;
      moved = shadow_heap[shadow_fill];
      pos   = 0;
      kid   = 1;
      while (kid < shadow_fill && !settled) begin
        if (kid + 1 < shadow_fill && shadow_heap[kid + 1].cost < shadow_heap[kid].cost)
          kid++;
        if (moved.cost <= shadow_heap[kid].cost) begin
          settled = 1'b1;
        end else begin
          shadow_heap[pos] = shadow_heap[kid];
          pos = kid;
          kid = 2 * pos + 1;
        end
      end
      shadow_heap[pos] = moved;
    end
    r.occupancy = shadow_fill[OCC_W-1:0];
    return r;
  endfunction

  // Random entry; tie-prone entries draw from a few small costs so that
  // equal keys meet often inside the heap.
  function automatic heap_entry_t random_entry(input bit tie_prone);
    heap_entry_t e;
    logic [31:0] word;
    word      = $urandom();
    e.cost    = tie_prone ? COST_W'($urandom_range(7)) : word[COST_W-1:0];
    e.row     = COORD_W'($urandom_range(COORD_MAX));
    e.col     = COORD_W'($urandom_range(COORD_MAX));
    e.heading = HEADING_BITS'($urandom_range(3));
    return e;
  endfunction

  // Offer one request, idling first at random, and hold it until accepted.
  // The expectation is queued at the accepting edge.
  task automatic send_request(input logic cmd, input heap_entry_t item);
    @(negedge clk);
    while (!steady_traffic && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_entry_cost    <= item.cost;
    in_entry_row     <= item.row;
    in_entry_col     <= item.col;
    in_entry_heading <= item.heading;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(predict_request(cmd, item));
  endtask

  // Pop on an empty heap straight after reset: flagged, payload zero.
  task automatic test_pop_on_empty();
    send_request(CMD_POP, random_entry(1'b0));
  endtask

  // Extreme field values, every heading, and a run of equal costs whose
  // payloads reveal the tie order; drain to empty and pop once more.
  task automatic test_extremes_and_ties();
    heap_entry_t set [10];
    set[0] = '{COST_MAX, COORD_MAX, COORD_MAX, HEAD_WEST};
    set[1] = '{'0, '0, '0, HEAD_NORTH};
    set[2] = '{COST_W'(5), COORD_W'(1), COORD_W'(2), HEAD_EAST};
    set[3] = '{COST_W'(5), COORD_W'(3), COORD_W'(4), HEAD_SOUTH};
    set[4] = '{COST_MAX, '0, COORD_MAX, HEAD_SOUTH};
    set[5] = '{COST_W'(5), COORD_W'(7), COORD_W'(8), HEAD_WEST};
    set[6] = '{'0, COORD_MAX, '0, HEAD_EAST};
    set[7] = '{COST_W'(5), COORD_W'(9), COORD_W'(10), HEAD_NORTH};
    set[8] = '{COST_W'(20'h55555), COORD_W'(21), COORD_W'(10), HEAD_EAST};
    set[9] = '{COST_W'(20'hAAAAA), COORD_W'(10), COORD_W'(21), HEAD_WEST};
    foreach (set[i]) send_request(CMD_PUSH, set[i]);
    repeat (11) send_request(CMD_POP, random_entry(1'b0));
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the output register fills and the input channel stalls.
  task automatic test_output_hold_off();
    rx_hold_cycles = 300;
    repeat (6) send_request(CMD_PUSH, random_entry(1'b1));
    repeat (7) send_request(CMD_POP, random_entry(1'b0));
  endtask

  // Mixed traffic: phases lean toward pushes then pops so the occupancy
  // rises and falls; one stretch runs with no idling on either side.
  task automatic test_random_traffic(input int count);
    int push_pct;
    for (int i = 0; i < count; i++) begin
      steady_traffic = (i >= 150 && i < 250);
      push_pct = (i % 100 < 60) ? 70 : 30;
      if ($urandom_range(99) < push_pct)
        send_request(CMD_PUSH, random_entry(1'($urandom_range(1))));
      else
        send_request(CMD_POP, random_entry(1'b0));
    end
    steady_traffic = 1'b0;
  endtask

  // Receiver: a requested hold-off wins, steady traffic keeps it ready, otherwise stall at random.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else if (steady_traffic) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result taken against the oldest expectation.
  always @(posedge clk) begin : check_results
    heap_result_t got;
    heap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{stat_code_t'(out_status), out_cost, out_row, out_col, out_heading,
              out_occupancy};
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result with no request awaiting it: status=%0d cost=%0h occupancy=%0d",
                   out_status, out_cost, out_occupancy);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch expected: status=%0d cost=%0h row=%0d col=%0d heading=%0d occ=%0d",
                     want.status, want.cost, want.row, want.col, want.heading, want.occupancy);
            $display("         actual:   status=%0d cost=%0h row=%0d col=%0d heading=%0d occ=%0d",
                     got.status, got.cost, got.row, got.col, got.heading, got.occupancy);
          end
        end
      end
    end
  end

  // Watchdog: end the run if it exceeds the cycle limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_PUSH;
    in_entry_cost    = '0;
    in_entry_row     = '0;
    in_entry_col     = '0;
    in_entry_heading = HEAD_NORTH;
    shadow_fill      = 0;
    mismatch_count   = 0;
    steady_traffic   = 1'b0;
    rx_hold_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pop_on_empty();
    test_extremes_and_ties();
    test_output_hold_off();
    test_random_traffic(365);

    // release the request channel, collect what is outstanding, then settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- binary_min_heap_queue_unit.f -----
rtl/bmhq_pkg.sv
rtl/bmhq_dp.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue_unit.sv
rtl/bmhq_checker.sv
tb/binary_min_heap_queue_unit_tb.sv
